@@ rtl/ffe_pkg.sv @@
// shared types, constants and helper functions for the framebuffer fill engine
`timescale 1ns / 1ps

package ffe_pkg;

    // field and register widths
    localparam int DIM_W      = 9;
    localparam int COORD_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 4 * CHAN_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // geometry defaults
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DIM_RESET      = 256;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // operation codes on the input channel
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FILL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // configuration register index
    typedef enum logic {
        REG_ACTIVE_WIDTH  = 1'b0,
        REG_ACTIVE_HEIGHT = 1'b1
    } reg_idx_t;

    // work kinds handed to the back end
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_FILL = 2'd1,
        CMD_READ = 2'd2
    } cmd_kind_t;

    // classified command: a half-open span to fill, or one pixel to read
    typedef struct packed {
        cmd_kind_t            kind;
        logic                 in_range;
        logic [DIM_W-1:0]     x0;
        logic [DIM_W-1:0]     x1;
        logic [DIM_W-1:0]     y0;
        logic [DIM_W-1:0]     y1;
        logic [PIXEL_W-1:0]   colour;
    } cmd_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_READ,
        ST_RESULT
    } back_state_t;

    // dimension register write: zero reads as one, saturate at the maximum
    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v,
                                                    input int unsigned      maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > maxv)
            r = DIM_W'(maxv);
        else
            r = v;
        return r;
    endfunction

    // clamp a signed coordinate to 0..lim
    function automatic logic [DIM_W-1:0] clip_coord(input logic signed [COORD_W-1:0] v,
                                                     input logic [DIM_W-1:0]          lim);
        logic signed [COORD_W:0] v_ext;
        logic signed [COORD_W:0] lim_ext;
        logic [DIM_W-1:0]        r;
        v_ext   = {v[COORD_W-1], v};
        lim_ext = {{(COORD_W+1-DIM_W){1'b0}}, lim};
        if (v_ext > lim_ext)
            r = lim;
        else if (v[COORD_W-1])
            r = '0;
        else
            r = v[DIM_W-1:0];
        return r;
    endfunction

    // position lies inside the active area
    function automatic logic pos_inside(input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic [DIM_W-1:0]          w,
                                        input logic [DIM_W-1:0]          h);
        logic [COORD_W-1:0] xu;
        logic [COORD_W-1:0] yu;
        xu = x;
        yu = y;
        return !x[COORD_W-1] && !y[COORD_W-1] &&
               (xu < COORD_W'(w)) && (yu < COORD_W'(h));
    endfunction

endpackage

@@ rtl/ffe_front.sv @@
// front end: takes input transactions and turns them into fill spans or reads
`timescale 1ns / 1ps

module ffe_front
    import ffe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [DIM_W-1:0]          active_width,
    input  logic [DIM_W-1:0]          active_height,
    input  logic                      accept_en,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                operation,
    input  logic signed [COORD_W-1:0] x_first,
    input  logic signed [COORD_W-1:0] y_first,
    input  logic signed [COORD_W-1:0] x_second,
    input  logic signed [COORD_W-1:0] y_second,
    input  logic [CHAN_W-1:0]         red_in,
    input  logic [CHAN_W-1:0]         green_in,
    input  logic [CHAN_W-1:0]         blue_in,
    input  logic [CHAN_W-1:0]         alpha_in,
    output logic                      push_valid,
    input  logic                      push_ready,
    output cmd_t                      push_cmd
);

    logic                      hold_valid_reg;
    logic                      hold_valid_next;
    op_t                       op_reg;
    logic signed [COORD_W-1:0] xa_reg;
    logic signed [COORD_W-1:0] ya_reg;
    logic signed [COORD_W-1:0] xb_reg;
    logic signed [COORD_W-1:0] yb_reg;
    logic [PIXEL_W-1:0]        colour_reg;
    logic                      in_fire;

    logic                      corners_equal;
    logic                      first_inside;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] hi_y;
    logic [DIM_W-1:0]          cx0;
    logic [DIM_W-1:0]          cx1;
    logic [DIM_W-1:0]          cy0;
    logic [DIM_W-1:0]          cy1;

    // one holding stage, refilled in the cycle it drains
    assign in_ready        = accept_en && (!hold_valid_reg || push_ready);
    assign in_fire         = in_valid && in_ready;
    assign push_valid      = hold_valid_reg;

    always_comb
    begin
        if (in_fire)
            hold_valid_next = 1'b1;
        else if (push_ready)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    // captured transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= op_t'(operation);
            xa_reg     <= x_first;
            ya_reg     <= y_first;
            xb_reg     <= x_second;
            yb_reg     <= y_second;
            colour_reg <= {alpha_in, blue_in, green_in, red_in};
        end
    end

    // corner ordering and clipping
    assign corners_equal = (xa_reg == xb_reg) && (ya_reg == yb_reg);
    assign first_inside  = pos_inside(xa_reg, ya_reg, active_width, active_height);
    assign lo_x          = (xa_reg < xb_reg) ? xa_reg : xb_reg;
    assign hi_x          = (xa_reg > xb_reg) ? xa_reg : xb_reg;
    assign lo_y          = (ya_reg < yb_reg) ? ya_reg : yb_reg;
    assign hi_y          = (ya_reg > yb_reg) ? ya_reg : yb_reg;
    assign cx0           = clip_coord(lo_x, active_width);
    assign cx1           = clip_coord(hi_x, active_width);
    assign cy0           = clip_coord(lo_y, active_height);
    assign cy1           = clip_coord(hi_y, active_height);

    // classification into a span, a read or nothing
    always_comb
    begin
        push_cmd        = '0;
        push_cmd.kind   = CMD_NONE;
        push_cmd.colour = colour_reg;
        unique case (op_reg)
            OP_WRITE:
            begin
                if (first_inside)
                begin
                    push_cmd.kind     = CMD_FILL;
                    push_cmd.in_range = 1'b1;
                    push_cmd.x0       = xa_reg[DIM_W-1:0];
                    push_cmd.x1       = xa_reg[DIM_W-1:0] + DIM_W'(1);
                    push_cmd.y0       = ya_reg[DIM_W-1:0];
                    push_cmd.y1       = ya_reg[DIM_W-1:0] + DIM_W'(1);
                end
            end
            OP_FILL:
            begin
                if (corners_equal)
                begin
                    if (first_inside)
                    begin
                        push_cmd.kind = CMD_FILL;
                        push_cmd.x0   = xa_reg[DIM_W-1:0];
                        push_cmd.x1   = xa_reg[DIM_W-1:0] + DIM_W'(1);
                        push_cmd.y0   = ya_reg[DIM_W-1:0];
                        push_cmd.y1   = ya_reg[DIM_W-1:0] + DIM_W'(1);
                    end
                end
                else if ((cx0 < cx1) && (cy0 < cy1))
                begin
                    push_cmd.kind = CMD_FILL;
                    push_cmd.x0   = cx0;
                    push_cmd.x1   = cx1;
                    push_cmd.y0   = cy0;
                    push_cmd.y1   = cy1;
                end
            end
            OP_CLEAR:
            begin
                push_cmd.kind = CMD_FILL;
                push_cmd.x0   = '0;
                push_cmd.x1   = active_width;
                push_cmd.y0   = '0;
                push_cmd.y1   = active_height;
            end
            OP_READ:
            begin
                if (first_inside)
                begin
                    push_cmd.kind     = CMD_READ;
                    push_cmd.in_range = 1'b1;
                    push_cmd.x0       = xa_reg[DIM_W-1:0];
                    push_cmd.y0       = ya_reg[DIM_W-1:0];
                end
            end
            default:
            begin
                push_cmd.kind = CMD_NONE;
            end
        endcase
    end

endmodule

@@ rtl/ffe_queue.sv @@
// short command queue between the front end and the back end
`timescale 1ns / 1ps

module ffe_queue
    import ffe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop && pop_valid;
    assign pop_cmd    = entry_mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            if (pop_fire)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
            entry_mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ rtl/ffe_back.sv @@
// back end: frame store, span sequencer, clearing pass and result register
`timescale 1ns / 1ps

module ffe_back
    import ffe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [DIM_W-1:0]   active_width,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               clear_busy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAN_W-1:0]  red_out,
    output logic [CHAN_W-1:0]  green_out,
    output logic [CHAN_W-1:0]  blue_out,
    output logic [CHAN_W-1:0]  alpha_out,
    output logic               in_range
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    back_state_t          state_reg;
    back_state_t          state_next;
    cmd_t                 cmd_reg;
    logic [ADDR_W-1:0]    row_base_reg;
    logic [DIM_W-1:0]     x_reg;
    logic [DIM_W-1:0]     y_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [PIXEL_W-1:0]   rd_data_reg;
    logic                 out_valid_reg;
    logic [PIXEL_W-1:0]   out_pixel_reg;
    logic                 out_in_range_reg;

    logic [PIXEL_W-1:0]   frame_mem [DEPTH];
    logic [2*DIM_W-1:0]   row_prod;
    logic [ADDR_W-1:0]    pix_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [PIXEL_W-1:0]   wr_data;
    logic                 clr_last;
    logic                 row_last;
    logic                 col_last;
    logic                 slot_free;
    logic                 mem_we;
    logic                 mem_re;
    logic                 out_load;

    // address arithmetic
    assign row_prod  = active_width * cmd_reg.y0;
    assign pix_addr  = row_base_reg + ADDR_W'(x_reg);
    assign clr_last  = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign row_last  = ((x_reg + DIM_W'(1)) == cmd_reg.x1);
    assign col_last  = ((y_reg + DIM_W'(1)) == cmd_reg.y1);
    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                case (cmd_reg.kind)
                    CMD_FILL: state_next = ST_FILL;
                    CMD_READ: state_next = ST_READ;
                    default:  state_next = ST_RESULT;
                endcase
            end
            ST_FILL:
            begin
                if (row_last && col_last)
                    state_next = ST_RESULT;
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                    state_next = q_valid ? ST_SETUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        clear_busy = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                clear_busy = 1'b1;
            end
            ST_IDLE:
            begin
                q_pop = q_valid;
            end
            ST_SETUP:
            begin
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_RESULT:
            begin
                out_load = slot_free;
                q_pop    = slot_free && q_valid;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (state_reg == ST_CLEAR)
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
    end

    // command and span walk
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_cmd;
        if (state_reg == ST_SETUP)
        begin
            row_base_reg <= ADDR_W'(row_prod);
            x_reg        <= cmd_reg.x0;
            y_reg        <= cmd_reg.y0;
        end
        else if (state_reg == ST_FILL)
        begin
            if (row_last)
            begin
                x_reg        <= cmd_reg.x0;
                y_reg        <= y_reg + DIM_W'(1);
                row_base_reg <= row_base_reg + ADDR_W'(active_width);
            end
            else
            begin
                x_reg <= x_reg + DIM_W'(1);
            end
        end
    end

    // frame store
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : pix_addr;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : cmd_reg.colour;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= frame_mem[pix_addr];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pixel_reg    <= (cmd_reg.kind == CMD_READ) ? rd_data_reg : '0;
            out_in_range_reg <= cmd_reg.in_range;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pixel_reg[CHAN_W-1:0];
    assign green_out = out_pixel_reg[2*CHAN_W-1:CHAN_W];
    assign blue_out  = out_pixel_reg[3*CHAN_W-1:2*CHAN_W];
    assign alpha_out = out_pixel_reg[4*CHAN_W-1:3*CHAN_W];
    assign in_range  = out_in_range_reg;

endmodule

@@ rtl/framebuffer_fill_engine.sv @@
// framebuffer fill engine top level: configuration registers and the front, queue, back chain
//
// Commands enter on the in_valid/in_ready channel: pixel write, rectangle fill, clear and
// pixel read. Every command returns one result transaction on out_valid/out_ready with the
// read colour (zero for other commands) and the in_range flag.
// active_width sits at APB address 0 and active_height at address 4; write them only while
// no command is outstanding.
// The back end sequencer takes each command through a setup state and a result state,
// with one fill step per pixel written by a write, fill or clear, or a read step for a read.
// The front end keeps classifying and queues up to four commands while the back end works.
// After reset the frame store is zeroed by a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries
// (65536 by default); in_ready stays low until it is done, APB writes are taken throughout.
// When the receiver stalls the result register holds, the back end waits on it, and the
// queue and then in_ready back up in turn.
`timescale 1ns / 1ps

module framebuffer_fill_engine
    import ffe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                operation,
    input  logic signed [COORD_W-1:0] x_first,
    input  logic signed [COORD_W-1:0] y_first,
    input  logic signed [COORD_W-1:0] x_second,
    input  logic signed [COORD_W-1:0] y_second,
    input  logic [CHAN_W-1:0]         red_in,
    input  logic [CHAN_W-1:0]         green_in,
    input  logic [CHAN_W-1:0]         blue_in,
    input  logic [CHAN_W-1:0]         alpha_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CHAN_W-1:0]         red_out,
    output logic [CHAN_W-1:0]         green_out,
    output logic [CHAN_W-1:0]         blue_out,
    output logic [CHAN_W-1:0]         alpha_out,
    output logic                      in_range
);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = dim_clamp(DIM_W'(DIM_RESET), MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = dim_clamp(DIM_W'(DIM_RESET), MAX_HEIGHT);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;
    logic             clear_busy;
    logic             push_valid;
    logic             push_ready;
    cmd_t             push_cmd;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_cmd;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ACTIVE_WIDTH:  width_reg  <= dim_clamp(pwdata[DIM_W-1:0], MAX_WIDTH);
                REG_ACTIVE_HEIGHT: height_reg <= dim_clamp(pwdata[DIM_W-1:0], MAX_HEIGHT);
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_ACTIVE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_ACTIVE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:           prdata = '0;
        endcase
    end

    // command classification
    ffe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .active_width  (width_reg),
        .active_height (height_reg),
        .accept_en     (!clear_busy),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .x_first       (x_first),
        .y_first       (y_first),
        .x_second      (x_second),
        .y_second      (y_second),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .alpha_in      (alpha_in),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    // decoupling queue
    ffe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    // frame store and execution
    ffe_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .active_width (width_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .clear_busy   (clear_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .alpha_out    (alpha_out),
        .in_range     (in_range)
    );

endmodule

@@ rtl/ffe_checker.sv @@
// port level checks for the framebuffer fill engine, bound to the top level
`timescale 1ns / 1ps

module ffe_checker
    import ffe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [CHAN_W-1:0]     red_out,
    input logic [CHAN_W-1:0]     green_out,
    input logic [CHAN_W-1:0]     blue_out,
    input logic [CHAN_W-1:0]     alpha_out,
    input logic                  in_range,
    input logic                  psel,
    input logic                  pwrite,
    input logic [APB_DATA_W-1:0] prdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable({red_out, green_out, blue_out, alpha_out, in_range}))
        else $error("result payload changed while stalled");

    // results without an in-range position carry no colour
    a_zero_colour: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |->
            (red_out == '0) && (green_out == '0) && (blue_out == '0) && (alpha_out == '0))
        else $error("colour returned for an out of range transaction");

    // dimension registers read back nonzero and within nine bits
    a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> (prdata[APB_DATA_W-1:DIM_W] == '0) && (prdata != '0))
        else $error("dimension register readback out of range");

endmodule

bind framebuffer_fill_engine ffe_checker u_ffe_checker (.*);

@@ tb/testbench.sv @@
// self-checking testbench for the framebuffer fill engine
`timescale 1ns / 1ps

module testbench;
    import ffe_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 70;
    localparam int DRAIN_LIMIT = 300000;

    // one drawing command as driven on the input channel
    typedef struct packed {
        op_t                      op;
        logic signed [COORD_W-1:0] xa;
        logic signed [COORD_W-1:0] ya;
        logic signed [COORD_W-1:0] xb;
        logic signed [COORD_W-1:0] yb;
        logic [CHAN_W-1:0]        red;
        logic [CHAN_W-1:0]        green;
        logic [CHAN_W-1:0]        blue;
        logic [CHAN_W-1:0]        alpha;
    } draw_cmd_t;

    // one result transaction
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              hit;
    } pixel_reading_t;

    // shadow frame store and queue of expected pixel readings
    class fill_scoreboard;
        bit [PIXEL_W-1:0] shadow_frame [STORE_DEPTH];
        int               width;
        int               height;
        pixel_reading_t   pending_pixels[$];
        int unsigned      errors;

        function new();
            width  = DEF_MAX_WIDTH;
            height = DEF_MAX_HEIGHT;
            errors = 0;
        endfunction

        function void flag(string what, logic [31:0] exp_val, logic [31:0] act_val);
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %0h, got %0h", what, exp_val, act_val);
        endfunction

        // dimension write: zero counts as one, saturate at the store size
        function void set_dim(reg_idx_t idx, logic [31:0] raw);
            int v;
            int lim;
            v   = int'(raw[DIM_W-1:0]);
            lim = (idx == REG_ACTIVE_WIDTH) ? DEF_MAX_WIDTH : DEF_MAX_HEIGHT;
            if (v < 1)
                v = 1;
            if (v > lim)
                v = lim;
            if (idx == REG_ACTIVE_WIDTH)
                width = v;
            else
                height = v;
        endfunction

        function int dim_of(reg_idx_t idx);
            return (idx == REG_ACTIVE_WIDTH) ? width : height;
        endfunction

        function bit covers(int x, int y);
            return x >= 0 && y >= 0 && x < width && y < height;
        endfunction

        function int clip_to(int v, int hi);
            if (v > hi)
                v = hi;
            if (v < 0)
                v = 0;
            return v;
        endfunction

        function void paint_span(int x0, int x1, int y0, int y1, bit [PIXEL_W-1:0] colour);
            for (int y = y0; y < y1; y++)
                for (int x = x0; x < x1; x++)
                    shadow_frame[x + width * y] = colour;
        endfunction

        // apply one accepted command to the shadow store and queue its reading
        function void note_command(draw_cmd_t c);
            int               xa;
            int               ya;
            int               xb;
            int               yb;
            bit [PIXEL_W-1:0] colour;
            bit [PIXEL_W-1:0] pix;
            pixel_reading_t   r;
            xa     = int'($signed(c.xa));
            ya     = int'($signed(c.ya));
            xb     = int'($signed(c.xb));
            yb     = int'($signed(c.yb));
            colour = {c.alpha, c.blue, c.green, c.red};
            r      = '0;
            case (c.op)
                OP_WRITE:
                begin
                    if (covers(xa, ya))
                    begin
                        shadow_frame[xa + width * ya] = colour;
                        r.hit = 1'b1;
                    end
                end
                OP_FILL:
                begin
                    // equal corners behave as a single pixel write
                    if (xa == xb && ya == yb)
                    begin
                        if (covers(xa, ya))
                            shadow_frame[xa + width * ya] = colour;
                    end
                    else
                    begin
                        paint_span(clip_to((xa < xb) ? xa : xb, width),
                                   clip_to((xa > xb) ? xa : xb, width),
                                   clip_to((ya < yb) ? ya : yb, height),
                                   clip_to((ya > yb) ? ya : yb, height), colour);
                    end
                end
                OP_CLEAR:
                    paint_span(0, width, 0, height, colour);
                default:
                begin
                    if (covers(xa, ya))
                    begin
                        pix     = shadow_frame[xa + width * ya];
                        r.red   = pix[7:0];
                        r.green = pix[15:8];
                        r.blue  = pix[23:16];
                        r.alpha = pix[31:24];
                        r.hit   = 1'b1;
                    end
                end
            endcase
            pending_pixels.insert(pending_pixels.size(), r);
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(pixel_reading_t got);
            pixel_reading_t exp_r;
            if (pending_pixels.size() == 0)
            begin
                flag("result with nothing pending", 32'd0, 32'(got));
                return;
            end
            exp_r = pending_pixels.pop_front();
            if (got.red !== exp_r.red)
                flag("red_out", 32'(exp_r.red), 32'(got.red));
            if (got.green !== exp_r.green)
                flag("green_out", 32'(exp_r.green), 32'(got.green));
            if (got.blue !== exp_r.blue)
                flag("blue_out", 32'(exp_r.blue), 32'(got.blue));
            if (got.alpha !== exp_r.alpha)
                flag("alpha_out", 32'(exp_r.alpha), 32'(got.alpha));
            if (got.hit !== exp_r.hit)
                flag("in_range", 32'(exp_r.hit), 32'(got.hit));
        endfunction
    endclass

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr    = '0;
    logic [APB_DATA_W-1:0]     pwdata   = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                operation = '0;
    logic signed [COORD_W-1:0] x_first  = '0;
    logic signed [COORD_W-1:0] y_first  = '0;
    logic signed [COORD_W-1:0] x_second = '0;
    logic signed [COORD_W-1:0] y_second = '0;
    logic [CHAN_W-1:0]         red_in   = '0;
    logic [CHAN_W-1:0]         green_in = '0;
    logic [CHAN_W-1:0]         blue_in  = '0;
    logic [CHAN_W-1:0]         alpha_in = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CHAN_W-1:0]         red_out;
    logic [CHAN_W-1:0]         green_out;
    logic [CHAN_W-1:0]         blue_out;
    logic [CHAN_W-1:0]         alpha_out;
    logic                      in_range;

    fill_scoreboard sb;
    bit             idle_on   = 1'b1;
    int             stall_left = 0;

    int unsigned geo_w [PHASES] = '{16, 0, 1, 511, 256, 7, 40};
    int unsigned geo_h [PHASES] = '{12, 0, 256, 257, 3, 33, 25};

    framebuffer_fill_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .x_first   (x_first),
        .y_first   (y_first),
        .x_second  (x_second),
        .y_second  (y_second),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .in_range  (in_range)
    );

    always #5 clk = ~clk;

    // result side: check accepted transactions, stall in random bursts
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result({red_out, green_out, blue_out, alpha_out, in_range});
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = int'($urandom_range(1, 17)) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // position for a write or read: mostly inside, some near edges, some anywhere
    function automatic logic signed [COORD_W-1:0] pick_spot(int lim);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return COORD_W'($urandom_range(0, lim - 1));
        else if (roll < 92)
            return COORD_W'(int'($urandom_range(0, lim + 6)) - 3);
        else
            return COORD_W'($urandom);
    endfunction

    // corner pair on one axis; only a wide axis may reach the extremes
    function automatic void pick_span(int lim, bit wide,
                                      output logic signed [COORD_W-1:0] a,
                                      output logic signed [COORD_W-1:0] b);
        int                        base;
        logic signed [COORD_W-1:0] t;
        if (wide && $urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       a = 16'sh8000;
                1:       a = 16'sh7fff;
                default: a = COORD_W'($urandom);
            endcase
            b = COORD_W'(int'($urandom_range(0, 12)) - 6);
            if ($urandom_range(0, 1))
            begin
                t = a;
                a = b;
                b = t;
            end
        end
        else
        begin
            base = int'($urandom_range(0, lim + 12)) - 6;
            a    = COORD_W'(base);
            if ($urandom_range(0, 9) == 0)
                b = a;
            else
                b = COORD_W'(base + int'($urandom_range(0, 20)) - 10);
        end
    endfunction

    // random command for the current geometry; full clears only on modest areas
    function automatic draw_cmd_t make_command(int w, int h);
        draw_cmd_t c;
        int        roll;
        bit        roomy;
        bit        wide_x;
        roomy   = (w * h <= 4096);
        c.red   = CHAN_W'($urandom);
        c.green = CHAN_W'($urandom);
        c.blue  = CHAN_W'($urandom);
        c.alpha = CHAN_W'($urandom);
        c.xb    = COORD_W'($urandom);
        c.yb    = COORD_W'($urandom);
        c.xa    = pick_spot(w);
        c.ya    = pick_spot(h);
        roll    = $urandom_range(0, 99);
        if (roll < 28)
            c.op = OP_WRITE;
        else if (roll < 55)
        begin
            c.op   = OP_FILL;
            wide_x = 1'($urandom_range(0, 1));
            pick_span(w, roomy || wide_x, c.xa, c.xb);
            pick_span(h, roomy || !wide_x, c.ya, c.yb);
            if ($urandom_range(0, 11) == 0)
            begin
                c.xb = c.xa;
                c.yb = c.ya;
            end
        end
        else if (roll < 94 || !roomy)
            c.op = OP_READ;
        else
            c.op = OP_CLEAR;
        return c;
    endfunction

    // present one command, optionally after a gap, and wait for acceptance
    task automatic send_item(draw_cmd_t c);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= c.op;
        x_first   <= c.xa;
        y_first   <= c.ya;
        x_second  <= c.xb;
        y_second  <= c.yb;
        red_in    <= c.red;
        green_in  <= c.green;
        blue_in   <= c.blue;
        alpha_in  <= c.alpha;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic send_draw(op_t op, int xa, int ya, int xb, int yb,
                             logic [PIXEL_W-1:0] colour);
        draw_cmd_t c;
        c.op    = op;
        c.xa    = COORD_W'(xa);
        c.ya    = COORD_W'(ya);
        c.xb    = COORD_W'(xb);
        c.yb    = COORD_W'(yb);
        c.red   = colour[7:0];
        c.green = colour[15:8];
        c.blue  = colour[23:16];
        c.alpha = colour[31:24];
        send_item(c);
    endtask

    // stop sending until every expected reading has come back
    task automatic hold_off();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // one apb transaction; leaves psel high for a back-to-back transfer
    task automatic apb_xfer(bit wr, reg_idx_t idx, logic [31:0] data,
                            output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(int'(idx) * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
    endtask

    // drain, write both dimensions, then read them back
    task automatic set_geometry(logic [31:0] w_raw, logic [31:0] h_raw);
        logic [31:0] got;
        hold_off();
        apb_xfer(1'b1, REG_ACTIVE_WIDTH, w_raw, got);
        sb.set_dim(REG_ACTIVE_WIDTH, w_raw);
        apb_xfer(1'b1, REG_ACTIVE_HEIGHT, h_raw, got);
        sb.set_dim(REG_ACTIVE_HEIGHT, h_raw);
        apb_xfer(1'b0, REG_ACTIVE_WIDTH, 32'd0, got);
        if (got !== 32'(sb.dim_of(REG_ACTIVE_WIDTH)))
            sb.flag("active_width readback", sb.dim_of(REG_ACTIVE_WIDTH), got);
        apb_xfer(1'b0, REG_ACTIVE_HEIGHT, 32'd0, got);
        if (got !== 32'(sb.dim_of(REG_ACTIVE_HEIGHT)))
            sb.flag("active_height readback", sb.dim_of(REG_ACTIVE_HEIGHT), got);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        int waited;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset geometry, corners, clipping and every operation
        send_draw(OP_READ, 0, 0, 0, 0, 32'h0);
        send_draw(OP_WRITE, 0, 0, 0, 0, 32'hffff_ffff);
        send_draw(OP_READ, 0, 0, 0, 0, 32'h0);
        send_draw(OP_WRITE, 255, 255, 0, 0, 32'h8040_2010);
        send_draw(OP_READ, 255, 255, 0, 0, 32'h0);
        send_draw(OP_WRITE, 256, 0, 0, 0, 32'h1234_5678);
        send_draw(OP_WRITE, 0, 256, 0, 0, 32'h1234_5678);
        send_draw(OP_WRITE, -1, 5, 0, 0, 32'h1234_5678);
        send_draw(OP_READ, -32768, 32767, 0, 0, 32'h0);
        send_draw(OP_READ, 32767, -32768, 0, 0, 32'h0);
        // equal corners act as a pixel write, skipped when outside
        send_draw(OP_FILL, 10, 10, 10, 10, 32'h1122_3344);
        send_draw(OP_READ, 10, 10, 0, 0, 32'h0);
        send_draw(OP_FILL, -5, -5, -5, -5, 32'h5566_7788);
        // zero-width span writes nothing
        send_draw(OP_FILL, 5, 3, 5, 9, 32'h99aa_bbcc);
        send_draw(OP_READ, 5, 3, 0, 0, 32'h0);
        // reversed corners, half-open span
        send_draw(OP_FILL, 20, 12, 14, 8, 32'hdead_beef);
        send_draw(OP_READ, 14, 8, 0, 0, 32'h0);
        send_draw(OP_READ, 19, 11, 0, 0, 32'h0);
        send_draw(OP_READ, 20, 12, 0, 0, 32'h0);
        // extreme corners clamp to the screen edges
        send_draw(OP_FILL, -32768, 2, 32767, 4, 32'h0f0f_f0f0);
        send_draw(OP_READ, 255, 3, 0, 0, 32'h0);
        send_draw(OP_FILL, 3, 32767, 5, -32768, 32'h7e81_18e7);
        send_draw(OP_READ, 4, 255, 0, 0, 32'h0);
        send_draw(OP_CLEAR, 0, 0, 0, 0, 32'h00a5_5a3c);
        send_draw(OP_READ, 128, 200, 0, 0, 32'h0);

        // random phases over a range of geometries
        for (int p = 0; p < PHASES; p++)
        begin
            set_geometry(geo_w[p], geo_h[p]);
            idle_on = (p != 2) && (p != PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_item(make_command(sb.width, sb.height));
                if (i < PHASE_ITEMS - 1 && $urandom_range(0, 49) == 0)
                    hold_off();
            end
        end

        // drain and let any stray transaction show up
        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #(30_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
